[design/tllc_pkg.sv]
package tllc_pkg;

   localparam int L1_SETS_DEF = 64;
   localparam int L1_WAYS_DEF = 4;
   localparam int L2_SETS_DEF = 512;
   localparam int L2_WAYS_DEF = 8;

   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int LAT_W      = 8;
   localparam int STALL_W    = 10;
   localparam int LEVEL_W    = 2;
   localparam int COUNT_W    = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_L1_OFFSET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_L1_INDEX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_L2_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_L2_INDEX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_L1_LAT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_L2_LAT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MEM_LAT   = 3'd6;

   // register reset values
   localparam logic [3:0]       L1_OFFSET_RST = 4'd2;
   localparam logic [2:0]       L1_INDEX_RST  = 3'd6;
   localparam logic [3:0]       L2_OFFSET_RST = 4'd2;
   localparam logic [3:0]       L2_INDEX_RST  = 4'd9;
   localparam logic [LAT_W-1:0] L1_LAT_RST    = 8'd1;
   localparam logic [LAT_W-1:0] L2_LAT_RST    = 8'd10;
   localparam logic [LAT_W-1:0] MEM_LAT_RST   = 8'd100;

   // hit level codes
   localparam logic [LEVEL_W-1:0] LEVEL_L1  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_L2  = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MEM = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_full;
   } ctrl_status_type;

   function automatic int min_one_clog2(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic int floor_log2(input int n);
      return $clog2(n + 1) - 1;
   endfunction

endpackage

[design/tllc_ram.sv]
module tllc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [tllc_pkg::min_one_clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [tllc_pkg::min_one_clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tllc_set_update.sv]
module tllc_set_update #(
   parameter int WAYS  = 4,
   parameter int AGE_W = 2
) (
   input  logic [WAYS*(1+AGE_W+tllc_pkg::TAG_W)-1:0] row_in,
   input  logic [tllc_pkg::TAG_W-1:0]                lookup_tag,
   output logic                                      hit,
   output logic [WAYS*(1+AGE_W+tllc_pkg::TAG_W)-1:0] row_out
);

   localparam int ENTRY_W = 1 + AGE_W + tllc_pkg::TAG_W;
   localparam int WAY_W   = tllc_pkg::min_one_clog2(WAYS);

   // entry layout: {valid, age, tag}
   always_comb begin
      logic                         v   [WAYS];
      logic [AGE_W-1:0]             a   [WAYS];
      logic [tllc_pkg::TAG_W-1:0]   t   [WAYS];
      logic                         nv;
      logic [AGE_W-1:0]             na;
      logic [tllc_pkg::TAG_W-1:0]   nt;
      logic                         hit_found;
      logic [WAY_W-1:0]             hit_way;
      logic                         free_found;
      logic [WAY_W-1:0]             free_way;
      logic [WAY_W-1:0]             oldest_way;
      logic [WAY_W-1:0]             victim;
      logic [AGE_W-1:0]             hit_age;
      hit_found  = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      free_way   = '0;
      oldest_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         v[w] = row_in[w*ENTRY_W + AGE_W + tllc_pkg::TAG_W];
         a[w] = row_in[w*ENTRY_W + tllc_pkg::TAG_W +: AGE_W];
         t[w] = row_in[w*ENTRY_W +: tllc_pkg::TAG_W];
      end
      for (int w = 0; w < WAYS; w++) begin
         if (!hit_found && v[w] && (t[w] == lookup_tag)) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(w);
         end
         if (!free_found && !v[w]) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
         // ages of a full set are distinct, so the oldest is the one at WAYS-1
         if (a[w] == AGE_W'(WAYS - 1)) begin
            oldest_way = WAY_W'(w);
         end
      end
      victim  = free_found ? free_way : oldest_way;
      hit_age = a[hit_way];
      for (int w = 0; w < WAYS; w++) begin
         nv = v[w];
         na = a[w];
         nt = t[w];
         if (hit_found) begin
            if (v[w] && (a[w] < hit_age)) begin
               na = a[w] + AGE_W'(1);
            end
            if (WAY_W'(w) == hit_way) begin
               na = '0;
            end
         end else begin
            if (v[w]) begin
               na = a[w] + AGE_W'(1);
            end
            if (WAY_W'(w) == victim) begin
               nv = 1'b1;
               na = '0;
               nt = lookup_tag;
            end
         end
         row_out[w*ENTRY_W +: ENTRY_W] = {nv, na, nt};
      end
      hit = hit_found;
   end

endmodule

[design/tllc_ctrl.sv]
module tllc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tllc_pkg::ctrl_status_type status,
   output tllc_pkg::ctrl_cmd_type    cmd
);

   tllc_pkg::state_type state_ff;
   tllc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tllc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tllc_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = tllc_pkg::ST_IDLE;
         end
         tllc_pkg::ST_IDLE: begin
            if (req_valid) state_in = tllc_pkg::ST_LOOKUP;
         end
         tllc_pkg::ST_LOOKUP: begin
            if (!status.out_full) state_in = tllc_pkg::ST_IDLE;
         end
         default: state_in = tllc_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tllc_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         tllc_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         tllc_pkg::ST_LOOKUP: begin
            cmd.commit = !status.out_full;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[design/tllc_datapath.sv]
module tllc_datapath #(
   parameter int L1_SETS = tllc_pkg::L1_SETS_DEF,
   parameter int L1_WAYS = tllc_pkg::L1_WAYS_DEF,
   parameter int L2_SETS = tllc_pkg::L2_SETS_DEF,
   parameter int L2_WAYS = tllc_pkg::L2_WAYS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tllc_pkg::ctrl_cmd_type             cmd,
   output tllc_pkg::ctrl_status_type          status,
   input  logic                               csr_write,
   input  logic [tllc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tllc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [tllc_pkg::ADDR_W-1:0]        req_address,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tllc_pkg::LEVEL_W-1:0]       rsp_hit_level,
   output logic [tllc_pkg::STALL_W-1:0]       rsp_stall_cycles,
   output logic [tllc_pkg::COUNT_W-1:0]       rsp_l1_miss_total,
   output logic [tllc_pkg::COUNT_W-1:0]       rsp_l2_miss_total
);

   localparam int L1_AGE_W  = tllc_pkg::min_one_clog2(L1_WAYS);
   localparam int L2_AGE_W  = tllc_pkg::min_one_clog2(L2_WAYS);
   localparam int L1_ROW_W  = L1_WAYS * (1 + L1_AGE_W + tllc_pkg::TAG_W);
   localparam int L2_ROW_W  = L2_WAYS * (1 + L2_AGE_W + tllc_pkg::TAG_W);
   localparam int L1_AW     = tllc_pkg::min_one_clog2(L1_SETS);
   localparam int L2_AW     = tllc_pkg::min_one_clog2(L2_SETS);
   localparam int L1_IDX_MAX = tllc_pkg::floor_log2(L1_SETS);
   localparam int L2_IDX_MAX = tllc_pkg::floor_log2(L2_SETS);
   localparam int CLR_ROWS  = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
   localparam int CLR_W     = tllc_pkg::min_one_clog2(CLR_ROWS);

   // configuration registers
   logic [3:0]                   l1_offset_ff, l2_offset_ff, l2_index_ff;
   logic [2:0]                   l1_index_ff;
   logic [tllc_pkg::LAT_W-1:0]   l1_lat_ff, l2_lat_ff, mem_lat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_offset_ff <= tllc_pkg::L1_OFFSET_RST;
         l1_index_ff  <= tllc_pkg::L1_INDEX_RST;
         l2_offset_ff <= tllc_pkg::L2_OFFSET_RST;
         l2_index_ff  <= tllc_pkg::L2_INDEX_RST;
         l1_lat_ff    <= tllc_pkg::L1_LAT_RST;
         l2_lat_ff    <= tllc_pkg::L2_LAT_RST;
         mem_lat_ff   <= tllc_pkg::MEM_LAT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            tllc_pkg::REG_L1_OFFSET: l1_offset_ff <= csr_wdata[3:0];
            tllc_pkg::REG_L1_INDEX:  l1_index_ff  <= csr_wdata[2:0];
            tllc_pkg::REG_L2_OFFSET: l2_offset_ff <= csr_wdata[3:0];
            tllc_pkg::REG_L2_INDEX:  l2_index_ff  <= csr_wdata[3:0];
            tllc_pkg::REG_L1_LAT:    l1_lat_ff    <= csr_wdata;
            tllc_pkg::REG_L2_LAT:    l2_lat_ff    <= csr_wdata;
            tllc_pkg::REG_MEM_LAT:   mem_lat_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // address split: clamped index width, tag above the index
   logic [3:0]                   l1_eff, l2_eff;
   logic [tllc_pkg::ADDR_W-1:0]  req_sh1, req_sh2;
   logic [L1_AW-1:0]             req_set1;
   logic [L2_AW-1:0]             req_set2;

   always_comb begin
      l1_eff   = ({1'b0, l1_index_ff} < 4'(L1_IDX_MAX)) ? {1'b0, l1_index_ff}
                                                        : 4'(L1_IDX_MAX);
      l2_eff   = (l2_index_ff < 4'(L2_IDX_MAX)) ? l2_index_ff : 4'(L2_IDX_MAX);
      req_sh1  = req_address >> l1_offset_ff;
      req_sh2  = req_address >> l2_offset_ff;
      req_set1 = req_sh1[L1_AW-1:0] & ((L1_AW'(1) << l1_eff) - L1_AW'(1));
      req_set2 = req_sh2[L2_AW-1:0] & ((L2_AW'(1) << l2_eff) - L2_AW'(1));
   end

   logic [tllc_pkg::ADDR_W-1:0]  addr_ff;
   logic [L1_AW-1:0]             set1_ff;
   logic [L2_AW-1:0]             set2_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff <= req_address;
         set1_ff <= req_set1;
         set2_ff <= req_set2;
      end
   end

   logic [tllc_pkg::TAG_W-1:0]   tag1, tag2;
   assign tag1 = addr_ff >> (5'(l1_offset_ff) + 5'(l1_eff));
   assign tag2 = addr_ff >> (5'(l2_offset_ff) + 5'(l2_eff));

   // clearing pass over the set rows after reset
   logic [CLR_W-1:0] clr_cnt_ff;
   logic             clr_l1, clr_l2;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
      end
   end

   assign clr_l1 = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(L1_SETS));
   assign clr_l2 = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(L2_SETS));

   logic [L1_ROW_W-1:0] l1_row, l1_row_new, l1_wr_data;
   logic [L2_ROW_W-1:0] l2_row, l2_row_new, l2_wr_data;
   logic [L1_AW-1:0]    l1_wr_addr;
   logic [L2_AW-1:0]    l2_wr_addr;
   logic                l1_wr_en, l2_wr_en, l1_hit, l2_hit;

   tllc_set_update #(.WAYS(L1_WAYS), .AGE_W(L1_AGE_W)) u_l1_update (
      .row_in     (l1_row),
      .lookup_tag (tag1),
      .hit        (l1_hit),
      .row_out    (l1_row_new)
   );

   tllc_set_update #(.WAYS(L2_WAYS), .AGE_W(L2_AGE_W)) u_l2_update (
      .row_in     (l2_row),
      .lookup_tag (tag2),
      .hit        (l2_hit),
      .row_out    (l2_row_new)
   );

   always_comb begin
      if (cmd.clear_en) begin
         l1_wr_en   = clr_l1;
         l2_wr_en   = clr_l2;
         l1_wr_addr = clr_cnt_ff[L1_AW-1:0];
         l2_wr_addr = clr_cnt_ff[L2_AW-1:0];
         l1_wr_data = '0;
         l2_wr_data = '0;
      end else begin
         l1_wr_en   = cmd.commit;
         l2_wr_en   = cmd.commit && !l1_hit;
         l1_wr_addr = set1_ff;
         l2_wr_addr = set2_ff;
         l1_wr_data = l1_row_new;
         l2_wr_data = l2_row_new;
      end
   end

   tllc_ram #(.WIDTH(L1_ROW_W), .DEPTH(L1_SETS)) u_l1_ram (
      .clock   (clock),
      .wr_en   (l1_wr_en),
      .wr_addr (l1_wr_addr),
      .wr_data (l1_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (req_set1),
      .rd_data (l1_row)
   );

   tllc_ram #(.WIDTH(L2_ROW_W), .DEPTH(L2_SETS)) u_l2_ram (
      .clock   (clock),
      .wr_en   (l2_wr_en),
      .wr_addr (l2_wr_addr),
      .wr_data (l2_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (req_set2),
      .rd_data (l2_row)
   );

   // result
   logic [tllc_pkg::LEVEL_W-1:0] level;
   logic [tllc_pkg::STALL_W-1:0] total, stall;
   logic [tllc_pkg::COUNT_W-1:0] l1_cnt_ff, l1_cnt_in, l2_cnt_ff, l2_cnt_in;

   always_comb begin
      if (l1_hit) begin
         level = tllc_pkg::LEVEL_L1;
      end else if (l2_hit) begin
         level = tllc_pkg::LEVEL_L2;
      end else begin
         level = tllc_pkg::LEVEL_MEM;
      end
      total = tllc_pkg::STALL_W'(l1_lat_ff)
            + (l1_hit ? '0 : tllc_pkg::STALL_W'(l2_lat_ff))
            + ((l1_hit || l2_hit) ? '0 : tllc_pkg::STALL_W'(mem_lat_ff));
      stall = (total == '0) ? '0 : total - tllc_pkg::STALL_W'(1);
      l1_cnt_in = l1_cnt_ff + tllc_pkg::COUNT_W'(!l1_hit);
      l2_cnt_in = l2_cnt_ff + tllc_pkg::COUNT_W'(!l1_hit && !l2_hit);
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_cnt_ff    <= '0;
         l2_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            l1_cnt_ff    <= l1_cnt_in;
            l2_cnt_ff    <= l2_cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_level     <= level;
         rsp_stall_cycles  <= stall;
         rsp_l1_miss_total <= l1_cnt_in;
         rsp_l2_miss_total <= l2_cnt_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign status.out_full   = rsp_valid_ff && !rsp_ready;
   assign status.clear_last = (clr_cnt_ff == CLR_W'(CLR_ROWS - 1));

endmodule

[design/two_level_lru_cache_model_unit.sv]
// Channel  Ports                              Direction  Moves
// req      req_valid/req_ready, req_address   in         one address item
// rsp      rsp_valid/rsp_ready, rsp_*         out        one result item per req item
// csr      csr_write, csr_index, csr_wdata    in         register write, no wait
//
// Steps: accept + set read, then lookup/update/write-back, one item at a time,
//   set by the single read then write of the tag/age row memories.
// Reset: a clearing pass over max(L1_SETS, L2_SETS) rows zeroes the valid bits
//   in both row memories; req_ready stays low until it ends, csr writes are taken.
// Stalls: a waiting result sits in the output register; the next item is still
//   accepted and only its write-back waits until rsp frees the register.
module two_level_lru_cache_model_unit #(
   parameter int L1_SETS = tllc_pkg::L1_SETS_DEF,
   parameter int L1_WAYS = tllc_pkg::L1_WAYS_DEF,
   parameter int L2_SETS = tllc_pkg::L2_SETS_DEF,
   parameter int L2_WAYS = tllc_pkg::L2_WAYS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [tllc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tllc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tllc_pkg::ADDR_W-1:0]        req_address,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tllc_pkg::LEVEL_W-1:0]       rsp_hit_level,
   output logic [tllc_pkg::STALL_W-1:0]       rsp_stall_cycles,
   output logic [tllc_pkg::COUNT_W-1:0]       rsp_l1_miss_total,
   output logic [tllc_pkg::COUNT_W-1:0]       rsp_l2_miss_total
);

   tllc_pkg::ctrl_cmd_type    cmd;
   tllc_pkg::ctrl_status_type status;

   // sequencer: clear pass, idle/accept, lookup/commit
   tllc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // row memories, set update logic, counters and result register
   tllc_datapath #(
      .L1_SETS (L1_SETS),
      .L1_WAYS (L1_WAYS),
      .L2_SETS (L2_SETS),
      .L2_WAYS (L2_WAYS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit_level     (rsp_hit_level),
      .rsp_stall_cycles  (rsp_stall_cycles),
      .rsp_l1_miss_total (rsp_l1_miss_total),
      .rsp_l2_miss_total (rsp_l2_miss_total)
   );

endmodule

[verif/two_level_lru_cache_model_unit_tb.sv]
`timescale 1ns / 100ps

module two_level_lru_cache_model_unit_tb;

   localparam int L1S = tllc_pkg::L1_SETS_DEF;
   localparam int L1W = tllc_pkg::L1_WAYS_DEF;
   localparam int L2S = tllc_pkg::L2_SETS_DEF;
   localparam int L2W = tllc_pkg::L2_WAYS_DEF;
   localparam int ITEMS_PER_PHASE = 160;

   typedef struct {
      logic [tllc_pkg::LEVEL_W-1:0] level;
      logic [tllc_pkg::STALL_W-1:0] stall;
      logic [tllc_pkg::COUNT_W-1:0] l1_total;
      logic [tllc_pkg::COUNT_W-1:0] l2_total;
   } access_result_type;

   // Cache predictor plus queue of expected access results.
   class cache_scoreboard_type;
      int unsigned cfg_val[7];
      logic [31:0] l1_tag[L1S*L1W];
      bit          l1_vld[L1S*L1W];
      int unsigned l1_age[L1S*L1W];
      logic [31:0] l2_tag[L2S*L2W];
      bit          l2_vld[L2S*L2W];
      int unsigned l2_age[L2S*L2W];
      logic [31:0] l1_miss_cnt, l2_miss_cnt;
      access_result_type pending_q[$];
      int          errors;

      function new();
         cfg_val[tllc_pkg::REG_L1_OFFSET] = tllc_pkg::L1_OFFSET_RST;
         cfg_val[tllc_pkg::REG_L1_INDEX]  = tllc_pkg::L1_INDEX_RST;
         cfg_val[tllc_pkg::REG_L2_OFFSET] = tllc_pkg::L2_OFFSET_RST;
         cfg_val[tllc_pkg::REG_L2_INDEX]  = tllc_pkg::L2_INDEX_RST;
         cfg_val[tllc_pkg::REG_L1_LAT]    = tllc_pkg::L1_LAT_RST;
         cfg_val[tllc_pkg::REG_L2_LAT]    = tllc_pkg::L2_LAT_RST;
         cfg_val[tllc_pkg::REG_MEM_LAT]   = tllc_pkg::MEM_LAT_RST;
         foreach (l1_vld[i]) l1_vld[i] = 0;
         foreach (l2_vld[i]) l2_vld[i] = 0;
         l1_miss_cnt = 0;
         l2_miss_cnt = 0;
         errors = 0;
      endfunction

      function void write_reg(int unsigned idx, logic [7:0] val);
         case (idx)
            tllc_pkg::REG_L1_OFFSET: cfg_val[idx] = val[3:0];
            tllc_pkg::REG_L1_INDEX:  cfg_val[idx] = val[2:0];
            tllc_pkg::REG_L2_OFFSET: cfg_val[idx] = val[3:0];
            tllc_pkg::REG_L2_INDEX:  cfg_val[idx] = val[3:0];
            tllc_pkg::REG_L1_LAT, tllc_pkg::REG_L2_LAT, tllc_pkg::REG_MEM_LAT:
               cfg_val[idx] = val;
            default: ;
         endcase
      endfunction

      function void split(logic [31:0] a, int unsigned off, int unsigned ib, int unsigned maxb,
                          output int unsigned set, output logic [31:0] tag);
         int unsigned eff;
         logic [63:0] w;
         eff = (ib < maxb) ? ib : maxb;
         w = {32'b0, a} >> off;
         set = int'(w & ((64'd1 << eff) - 1));
         tag = w[31:0] >> eff;
      endfunction

      function void note_access(logic [31:0] addr);
         int unsigned s1, s2, b1, b2, total, victim;
         logic [31:0] t1, t2;
         int hit;
         access_result_type r;
         split(addr, cfg_val[tllc_pkg::REG_L1_OFFSET], cfg_val[tllc_pkg::REG_L1_INDEX],
               $clog2(L1S), s1, t1);
         split(addr, cfg_val[tllc_pkg::REG_L2_OFFSET], cfg_val[tllc_pkg::REG_L2_INDEX],
               $clog2(L2S), s2, t2);
         b1 = s1 * L1W;
         b2 = s2 * L2W;
         hit = -1;
         for (int w = L1W - 1; w >= 0; w--)
            if (l1_vld[b1+w] && l1_tag[b1+w] == t1) hit = w;
         if (hit >= 0) begin
            for (int w = 0; w < L1W; w++)
               if (l1_vld[b1+w] && l1_age[b1+w] < l1_age[b1+hit]) l1_age[b1+w]++;
            l1_age[b1+hit] = 0;
            r.level = tllc_pkg::LEVEL_L1;
            total = cfg_val[tllc_pkg::REG_L1_LAT];
         end else begin
            l1_miss_cnt++;
            for (int w = L2W - 1; w >= 0; w--)
               if (l2_vld[b2+w] && l2_tag[b2+w] == t2) hit = w;
            if (hit >= 0) begin
               for (int w = 0; w < L2W; w++)
                  if (l2_vld[b2+w] && l2_age[b2+w] < l2_age[b2+hit]) l2_age[b2+w]++;
               l2_age[b2+hit] = 0;
               r.level = tllc_pkg::LEVEL_L2;
               total = cfg_val[tllc_pkg::REG_L1_LAT] + cfg_val[tllc_pkg::REG_L2_LAT];
            end else begin
               l2_miss_cnt++;
               r.level = tllc_pkg::LEVEL_MEM;
               total = cfg_val[tllc_pkg::REG_L1_LAT] + cfg_val[tllc_pkg::REG_L2_LAT]
                     + cfg_val[tllc_pkg::REG_MEM_LAT];
            end
            // L1 fill: first invalid way, else oldest (last on ties)
            victim = L1W;
            for (int w = L1W - 1; w >= 0; w--) if (!l1_vld[b1+w]) victim = w;
            if (victim == L1W) begin
               victim = 0;
               for (int w = 0; w < L1W; w++) if (l1_age[b1+w] >= l1_age[b1+victim]) victim = w;
            end
            for (int w = 0; w < L1W; w++) if (l1_vld[b1+w]) l1_age[b1+w]++;
            l1_tag[b1+victim] = t1;
            l1_vld[b1+victim] = 1;
            l1_age[b1+victim] = 0;
            if (r.level == tllc_pkg::LEVEL_MEM) begin
               victim = L2W;
               for (int w = L2W - 1; w >= 0; w--) if (!l2_vld[b2+w]) victim = w;
               if (victim == L2W) begin
                  victim = 0;
                  for (int w = 0; w < L2W; w++)
                     if (l2_age[b2+w] >= l2_age[b2+victim]) victim = w;
               end
               for (int w = 0; w < L2W; w++) if (l2_vld[b2+w]) l2_age[b2+w]++;
               l2_tag[b2+victim] = t2;
               l2_vld[b2+victim] = 1;
               l2_age[b2+victim] = 0;
            end
         end
         r.stall = (total > 0) ? tllc_pkg::STALL_W'(total - 1) : '0;
         r.l1_total = l1_miss_cnt;
         r.l2_total = l2_miss_cnt;
         pending_q.insert(pending_q.size(), r);
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      endfunction

      function void check_result(access_result_type got);
         access_result_type want;
         if (pending_q.size() == 0) begin
            report("unexpected result item", 1, 0);
            return;
         end
         want = pending_q.pop_front();
         if (got.level !== want.level) report("hit_level", got.level, want.level);
         if (got.stall !== want.stall) report("stall_cycles", got.stall, want.stall);
         if (got.l1_total !== want.l1_total)
            report("l1_miss_total", got.l1_total, want.l1_total);
         if (got.l2_total !== want.l2_total)
            report("l2_miss_total", got.l2_total, want.l2_total);
      endfunction
   endclass

   logic                            clock = 0;
   logic                            reset = 1;
   logic                            csr_write = 0;
   logic [tllc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [tllc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            req_valid = 0;
   logic                            req_ready;
   logic [tllc_pkg::ADDR_W-1:0]     req_address = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 0;
   logic [tllc_pkg::LEVEL_W-1:0]    rsp_hit_level;
   logic [tllc_pkg::STALL_W-1:0]    rsp_stall_cycles;
   logic [tllc_pkg::COUNT_W-1:0]    rsp_l1_miss_total;
   logic [tllc_pkg::COUNT_W-1:0]    rsp_l2_miss_total;

   cache_scoreboard_type sb = new();
   int  results_seen = 0;
   logic [31:0] addr_pool[48];

   two_level_lru_cache_model_unit DUT (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Watchdog: the slowest legal run is far below this.
   initial begin
      #800000;
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: compare every accepted item against the oldest prediction.
   always @(posedge clock) begin
      access_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.level = rsp_hit_level;
         got.stall = rsp_stall_cycles;
         got.l1_total = rsp_l1_miss_total;
         got.l2_total = rsp_l2_miss_total;
         sb.check_result(got);
         results_seen++;
      end
   end

   // Receiver stall pattern: free-running stretches, random stalls, and one
   // long hold-off so the block backs up and drops req_ready.
   initial begin
      int mode_len;
      bit held;
      held = 0;
      @(negedge reset);
      forever begin
         if (!held && results_seen >= 300) begin
            held = 1;
            rsp_ready <= 0;
            repeat (250) @(posedge clock);
         end
         mode_len = $urandom_range(5, 40);
         if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 1;
            repeat (mode_len) @(posedge clock);
         end else begin
            repeat (mode_len) begin
               rsp_ready <= ($urandom_range(0, 2) != 0);
               @(posedge clock);
            end
         end
      end
   end

   // Offer one address; hold it until taken. Valid stays high for the caller.
   task automatic send_addr(logic [31:0] addr);
      req_valid   <= 1;
      req_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_access(addr);
   endtask

   task automatic idle_sender(int cycles);
      req_valid <= 0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender pauses until every predicted item has come back, plus pipeline slack.
   task automatic drain_results();
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes indexes 0..6 and the unused index 7, which must be ignored.
   task automatic load_config(int unsigned l1o, l1i, l2o, l2i, l1l, l2l, ml);
      int unsigned vals[8];
      vals = '{l1o, l1i, l2o, l2i, l1l, l2l, ml, $urandom_range(0, 255)};
      for (int i = 0; i < 8; i++) begin
         csr_write <= 1;
         csr_index <= tllc_pkg::CSR_IDX_W'(i);
         csr_wdata <= tllc_pkg::CSR_DATA_W'(vals[i]);
         @(posedge clock);
         sb.write_reg(i, tllc_pkg::CSR_DATA_W'(vals[i]));
      end
      csr_write <= 0;
   endtask

   // Mostly reuse of a small address pool (hits, evictions, L2 refills),
   // with some fully random addresses and corner values as noise.
   function automatic logic [31:0] pick_addr();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 5) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      if (sel < 20) return $urandom;
      return addr_pool[$urandom_range(0, 47)] ^ ($urandom & 32'h0000_0003);
   endfunction

   task automatic run_random(int n);
      int sent = 0;
      int burst;
      foreach (addr_pool[i]) begin
         // pool members share sets so ways get evicted and refilled
         addr_pool[i] = ($urandom & 32'hFFFF_F000) | (($urandom_range(0, 3)) << 8)
                        | ($urandom & 32'h0000_00FC);
         if ($urandom_range(0, 3) == 0) addr_pool[i] = addr_pool[i] & 32'h0000_3FFF;
      end
      while (sent < n) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && sent < n; i++) begin
            send_addr(pick_addr());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
      end
      req_valid <= 0;
   endtask

   initial begin
      logic [31:0] directed[$];
      repeat (5) @(posedge clock);
      reset <= 0;

      // Reset config: cold misses, L1 hits, extremes, then five tags on one
      // L1 set (four ways) so the first one is evicted and comes back from L2.
      directed = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 32'h0000_4000,
                   32'h0000_5000, 32'h0000_1000, 32'h0000_1003, 32'h5555_5555};
      foreach (directed[i]) send_addr(directed[i]);
      idle_sender(1);
      run_random(ITEMS_PER_PHASE);
      drain_results();

      // One set per level, maximum latencies.
      load_config(0, 0, 0, 0, 255, 255, 255);
      run_random(ITEMS_PER_PHASE);
      drain_results();

      // Widest offsets and index widths past the clamp, minimum latencies.
      load_config(8, 7, 8, 15, 1, 1, 1);
      run_random(ITEMS_PER_PHASE);
      drain_results();

      // Offsets beyond the documented range, zero latencies (stall saturates).
      load_config(15, 3, 12, 5, 0, 0, 0);
      send_addr(32'h0);
      send_addr(32'h0);
      run_random(ITEMS_PER_PHASE);
      drain_results();

      load_config(4, 2, 5, 4, 7, 20, 200);
      run_random(ITEMS_PER_PHASE);
      drain_results();

      load_config(2, 6, 2, 9, 1, 10, 100);
      run_random(ITEMS_PER_PHASE);

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[two_level_lru_cache_model_unit.f]
design/tllc_pkg.sv
design/tllc_ram.sv
design/tllc_set_update.sv
design/tllc_ctrl.sv
design/tllc_datapath.sv
design/two_level_lru_cache_model_unit.sv
verif/two_level_lru_cache_model_unit_tb.sv
